// ===== hw/rtl/aiq_pkg.sv =====
// Shared types and constants of the absmax INT8 group quantizer.
package aiq_pkg;

  // Field widths
  localparam int unsigned SampleW  = 24;
  localparam int unsigned IdxW     = 15;
  localparam int unsigned QuantW   = 8;
  localparam int unsigned CountW   = 16;

  // Grouping: 128 elements per group, 32768 elements per vector
  localparam int unsigned GroupSize = 128;
  localparam int unsigned MaxLength = 32768;
  localparam int unsigned GrpBits   = $clog2(GroupSize);
  localparam int unsigned NumGroups = MaxLength / GroupSize;
  localparam int unsigned GaddrW    = $clog2(NumGroups);

  // Divider widths: numerator 254*|v| + absmax, divisor 2*absmax
  localparam int unsigned NumW   = 32;
  localparam int unsigned DivSteps = 8;
  localparam int unsigned StepW  = $clog2(DivSteps);

  localparam logic [QuantW-1:0] QMax     = 8'd127;
  localparam logic [CountW-1:0] CountMax = '1;

  // Action codes
  localparam logic ActMeasure  = 1'b0;
  localparam logic ActQuantize = 1'b1;

  // Input beat
  typedef struct packed {
    logic                      action;
    logic [IdxW-1:0]           element_index;
    logic signed [SampleW-1:0] sample;
  } in_beat_t;

  // Result beat
  typedef struct packed {
    logic signed [QuantW-1:0] quant_value;
    logic                     zero_flag;
    logic                     clip_flag;
    logic [SampleW-1:0]       scale_absmax;
    logic [CountW-1:0]        zeros_so_far;
    logic [CountW-1:0]        clips_so_far;
  } out_beat_t;

  // Controller to datapath commands
  typedef struct packed {
    logic             capture;
    logic             meas_upd;
    logic             q_prep;
    logic             div_step;
    logic [StepW-1:0] div_shift;
    logic             out_load;
  } aiq_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic action;
    logic out_free;
  } aiq_sts_t;

endpackage

// ===== hw/rtl/aiq_ctrl.sv =====
// Sequencing state machine of the quantizer.
module aiq_ctrl import aiq_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  aiq_sts_t sts_i,
  output aiq_cmd_t cmd_o
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_READ  = 6'b000010,
    S_MUPD  = 6'b000100,
    S_QPREP = 6'b001000,
    S_QDIV  = 6'b010000,
    S_QOUT  = 6'b100000
  } state_e;

  state_e           state_q, state_d;
  logic [StepW-1:0] cnt_q, cnt_d;

  assign in_ready_o = (state_q == S_IDLE);

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    cmd_o.div_shift = cnt_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_READ;
        end
      end
      S_READ: begin
        // group maximum is being read
        state_d = (sts_i.action == ActQuantize) ? S_QPREP : S_MUPD;
      end
      S_MUPD: begin
        cmd_o.meas_upd = 1'b1;
        state_d        = S_IDLE;
      end
      S_QPREP: begin
        cmd_o.q_prep = 1'b1;
        cnt_d        = StepW'(DivSteps - 1);
        state_d      = S_QDIV;
      end
      S_QDIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = S_QOUT;
        end
      end
      S_QOUT: begin
        // hold until the result register is free
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

// ===== hw/rtl/aiq_dpath.sv =====
// Datapath: maxima store, restoring divider, counters and result register.
module aiq_dpath import aiq_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  in_beat_t  in_data_i,
  input  logic      cfg_we_i,
  input  logic      cfg_data_i,
  input  aiq_cmd_t  cmd_i,
  output aiq_sts_t  sts_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_beat_t out_data_o
);

  // Captured beat
  logic               act_q;
  logic [IdxW-1:0]    idx_q;
  logic               neg_q;
  logic [SampleW-1:0] mag_q;
  logic [SampleW-1:0] raw;
  logic [SampleW-1:0] mag_d;

  // State
  logic               mode_q;
  logic [SampleW-1:0] tensor_q;
  logic [SampleW-1:0] grp_mem [NumGroups];
  logic [SampleW-1:0] grp_rd_q;
  logic [GaddrW-1:0]  gaddr;
  logic               idx_zero, grp_first, grp_ld;

  // Divider
  logic [SampleW-1:0] amax_q, amax_d;
  logic [NumW-1:0]    rem_q;
  logic [NumW-1:0]    trial;
  logic [QuantW-1:0]  quo_q;

  // Result
  logic [QuantW-1:0]  qmag;
  logic               clip, zero;
  logic [CountW-1:0]  zeros_q, clips_q, zbase, cbase;
  logic               out_valid_q;
  out_beat_t          out_q, out_d;

  assign raw   = in_data_i.sample;
  assign mag_d = raw[SampleW-1] ? (~raw + SampleW'(1)) : raw;

  assign gaddr     = idx_q[IdxW-1 -: GaddrW];
  assign idx_zero  = (idx_q == '0);
  assign grp_first = (idx_q[GrpBits-1:0] == '0);
  assign grp_ld    = grp_first || (mag_q > grp_rd_q);

  // Input capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      act_q <= in_data_i.action;
      idx_q <= in_data_i.element_index;
      neg_q <= raw[SampleW-1];
      mag_q <= mag_d;
    end
  end

  // Configuration register and tensor maximum
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= 1'b0;
      tensor_q <= '0;
    end else begin
      if (cfg_we_i) begin
        mode_q <= cfg_data_i;
      end
      if (cmd_i.meas_upd && (idx_zero || (mag_q > tensor_q))) begin
        tensor_q <= mag_q;
      end
    end
  end

  // Group maximum store, registered read
  always_ff @(posedge clk_i) begin
    grp_rd_q <= grp_mem[gaddr];
    if (cmd_i.meas_upd && grp_ld) begin
      grp_mem[gaddr] <= mag_q;
    end
  end

  // Restoring division, one quotient bit a cycle, most significant first
  assign amax_d = mode_q ? grp_rd_q : tensor_q;
  assign trial  = NumW'({amax_q, 1'b0}) << cmd_i.div_shift;

  always_ff @(posedge clk_i) begin
    if (cmd_i.q_prep) begin
      amax_q <= amax_d;
      // 254*|v| + absmax
      rem_q  <= (NumW'(mag_q) << 8) - (NumW'(mag_q) << 1) + NumW'(amax_d);
      quo_q  <= '0;
    end else if (cmd_i.div_step) begin
      if (rem_q >= trial) begin
        rem_q <= rem_q - trial;
        quo_q[cmd_i.div_shift] <= 1'b1;
      end
    end
  end

  // Clip above 127; a zero maximum gives zero
  always_comb begin
    clip = 1'b0;
    qmag = '0;
    if (amax_q != '0) begin
      clip = quo_q[QuantW-1];
      qmag = clip ? QMax : {1'b0, quo_q[QuantW-2:0]};
    end
    zero  = (qmag == '0);
    zbase = idx_zero ? '0 : zeros_q;
    cbase = idx_zero ? '0 : clips_q;
  end

  // Result beat
  always_comb begin
    out_d.quant_value  = neg_q ? (~qmag + QuantW'(1)) : qmag;
    out_d.zero_flag    = zero;
    out_d.clip_flag    = clip;
    out_d.scale_absmax = amax_q;
    out_d.zeros_so_far = zbase + CountW'(zero && (zbase != CountMax));
    out_d.clips_so_far = cbase + CountW'(clip && (cbase != CountMax));
  end

  // Running counts and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zeros_q     <= '0;
      clips_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.out_load) begin
        zeros_q     <= out_d.zeros_so_far;
        clips_q     <= out_d.clips_so_far;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_data_o     = out_q;
  assign sts_o.action   = act_q;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

endmodule

// ===== hw/rtl/absmax_int8_group_quantizer.sv =====
// Top level of the absmax INT8 group quantizer.
//
//   port group        dir  handshake            payload
//   in_*              in   in_valid_i/in_ready_o    in_beat_t  (action, index, sample)
//   out_*             out  out_valid_o/out_ready_i  out_beat_t (q, flags, scale, counts)
//   cfg_*             in   cfg_we_i, no wait        per_group_mode
//
// A measure beat runs through capture, store read and store/maximum update.
// A quantize beat runs through capture, store read, numerator set-up,
// 8 steps of the restoring divider and result load.
// Reset clears the tensor maximum, counts, mode and control; the group store
// is not cleared. A stalled result stays in the output register while the
// next beat is taken; a quantize result waits for that register to free.
module absmax_int8_group_quantizer import aiq_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_beat_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_beat_t out_data_o,
  input  logic      cfg_we_i,
  input  logic      cfg_data_i
);

  aiq_cmd_t cmd;
  aiq_sts_t sts;

  aiq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  aiq_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== tb/absmax_int8_group_quantizer_test.sv =====
// Self-checking testbench for the absmax INT8 group quantizer: directed and random vector passes.
module absmax_int8_group_quantizer_test;
  import aiq_pkg::*;

  // Settling time after the last result, enough for a measure or quantize beat in flight
  localparam int unsigned SettleCycles = 24;
  localparam int unsigned RunLimit     = 2000000;

  logic      clk_i     = 1'b0;
  logic      rst_ni    = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_beat_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_beat_t out_data;
  logic      cfg_we    = 1'b0;
  logic      cfg_data  = 1'b0;

  // Predicted block state
  logic [SampleW-1:0] tensor_peak = '0;
  logic [SampleW-1:0] group_peak [NumGroups];
  bit                 group_seen [NumGroups];
  int unsigned        seen_groups [$];
  logic [CountW-1:0]  zero_run    = '0;
  logic [CountW-1:0]  clip_run    = '0;
  logic               group_mode  = 1'b0;

  out_beat_t          awaited_codes [$];
  int unsigned        error_count   = 0;
  int unsigned        beats_sent    = 0;
  int unsigned        send_idle_pct = 0;
  int unsigned        recv_idle_pct = 0;
  logic [IdxW-1:0]    last_index;

  absmax_int8_group_quantizer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_data_i  (cfg_data)
  );

  always #1 clk_i = ~clk_i;

  // Advance the predicted state by one accepted beat; a quantize beat queues its code
  function automatic void predict_quantised(input in_beat_t b);
    logic [GaddrW-1:0]  g;
    logic [SampleW-1:0] mag;
    logic [SampleW-1:0] peak;
    longint unsigned    num;
    longint unsigned    den;
    longint unsigned    q;
    logic               clip;
    out_beat_t          r;
    g   = b.element_index[IdxW-1 -: GaddrW];
    mag = b.sample[SampleW-1] ? -b.sample : b.sample;
    if (b.action == ActMeasure) begin
      // index 0 restarts the tensor maximum, a group's first element restarts its own
      if (b.element_index == '0 || mag > tensor_peak) tensor_peak = mag;
      if (b.element_index[GrpBits-1:0] == '0 || mag > group_peak[g]) group_peak[g] = mag;
      if (!group_seen[g]) begin
        group_seen[g] = 1'b1;
        seen_groups.insert(seen_groups.size(), 32'(g));
      end
      return;
    end
    if (b.element_index == '0) begin
      zero_run = '0;
      clip_run = '0;
    end
    peak = group_mode ? group_peak[g] : tensor_peak;
    q    = 0;
    clip = 1'b0;
    // round half away from zero on the magnitude; zero maximum gives zero
    if (peak != '0) begin
      num = mag;
      num = num * 254 + peak;
      den = peak;
      den = den * 2;
      q   = num / den;
      if (q > QMax) begin
        q    = QMax;
        clip = 1'b1;
      end
    end
    if (q == 0 && zero_run != CountMax) zero_run++;
    if (clip && clip_run != CountMax) clip_run++;
    r.quant_value  = b.sample[SampleW-1] ? -q[QuantW-1:0] : q[QuantW-1:0];
    r.zero_flag    = (q == 0);
    r.clip_flag    = clip;
    r.scale_absmax = peak;
    r.zeros_so_far = zero_run;
    r.clips_so_far = clip_run;
    awaited_codes.insert(awaited_codes.size(), r);
  endfunction

  // Send one beat; indices are steered away from group maxima never written
  task automatic send_beat(input logic act, input logic [IdxW-1:0] idx,
                           input logic signed [SampleW-1:0] smp);
    logic [GaddrW-1:0] g;
    in_beat_t          b;
    g = idx[IdxW-1 -: GaddrW];
    if (act == ActMeasure) begin
      if (!group_seen[g]) idx[GrpBits-1:0] = '0;
    end else if (group_mode && !group_seen[g] && seen_groups.size() != 0) begin
      idx[IdxW-1 -: GaddrW] = GaddrW'(seen_groups[$urandom_range(seen_groups.size() - 1)]);
    end
    b.action        = act;
    b.element_index = idx;
    b.sample        = smp;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    @(posedge clk_i);
    while (in_ready !== 1'b1) @(posedge clk_i);
    predict_quantised(b);
    last_index = idx;
    beats_sent++;
    @(negedge clk_i);
  endtask

  // Hold off the sender until every awaited code is back and the block is idle
  task automatic settle();
    in_valid <= 1'b0;
    @(negedge clk_i);
    while (awaited_codes.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_mode(input logic m);
    settle();
    cfg_we   <= 1'b1;
    cfg_data <= m;
    @(negedge clk_i);
    cfg_we     <= 1'b0;
    group_mode = m;
  endtask

  // Random sample of random magnitude width, so both small values and clipping occur
  function automatic logic signed [SampleW-1:0] rand_sample();
    int unsigned        w;
    logic [SampleW-1:0] v;
    w = $urandom_range(SampleW);
    v = SampleW'($urandom);
    if (w < SampleW) begin
      v = v & ((SampleW'(1) << w) - 1'b1);
      if ($urandom_range(1) == 1) v = -v;
    end
    return v;
  endfunction

  task automatic report_field(input string name, input logic signed [31:0] want_v,
                              input logic signed [31:0] got_v);
    if (want_v !== got_v) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want_v, got_v);
      error_count++;
    end
  endtask

  // Result side: random back-pressure, and compare each beat with the oldest prediction
  always @(negedge clk_i) out_ready <= ($urandom_range(99) >= recv_idle_pct);

  always @(posedge clk_i) begin
    out_beat_t want;
    if (rst_ni && out_valid === 1'b1 && out_ready) begin
      if (awaited_codes.size() == 0) begin
        $display("%0t: unexpected result beat: expected none, actual %p", $time, out_data);
        error_count++;
      end else begin
        want = awaited_codes.pop_front();
        report_field("quant_value", 32'(want.quant_value), 32'(out_data.quant_value));
        report_field("zero_flag", 32'(want.zero_flag), 32'(out_data.zero_flag));
        report_field("clip_flag", 32'(want.clip_flag), 32'(out_data.clip_flag));
        report_field("scale_absmax", 32'(want.scale_absmax), 32'(out_data.scale_absmax));
        report_field("zeros_so_far", 32'(want.zeros_so_far), 32'(out_data.zeros_so_far));
        report_field("clips_so_far", 32'(want.clips_so_far), 32'(out_data.clips_so_far));
      end
    end
  end

  // Reset leaves per-tensor mode and a zero tensor maximum
  task automatic test_reset_scale_zero();
    send_beat(ActQuantize, 15'd0, 24'sd8388607);
  endtask

  // Extreme samples and indices through a per-tensor pass
  task automatic test_field_extremes();
    send_beat(ActMeasure, 15'd0, -24'sd8388608);
    send_beat(ActMeasure, 15'd1, 24'sd8388607);
    send_beat(ActMeasure, 15'd128, 24'sd254);
    send_beat(ActMeasure, 15'd32640, -24'sd3);
    send_beat(ActMeasure, 15'd32767, 24'sd2);
    send_beat(ActQuantize, 15'd0, -24'sd8388608);
    send_beat(ActQuantize, 15'd1, 24'sd8388607);
    send_beat(ActQuantize, 15'd32767, 24'sd0);
    send_beat(ActQuantize, 15'd2, 24'sd1);
  endtask

  // Per-group scaling: ties round away from zero, oversize samples clip
  task automatic test_group_rounding();
    write_mode(1'b1);
    send_beat(ActQuantize, 15'd129, -24'sd1);
    send_beat(ActQuantize, 15'd130, 24'sd3);
    send_beat(ActQuantize, 15'd131, 24'sd8388607);
    send_beat(ActQuantize, 15'd32767, -24'sd8388608);
    send_beat(ActQuantize, 15'd127, -24'sd8388608);
    send_beat(ActQuantize, 15'd0, 24'sd4);
  endtask

  // A group whose maximum is zero, then clipping against a small tensor maximum
  task automatic test_zero_and_clip();
    send_beat(ActMeasure, 15'd256, 24'sd0);
    send_beat(ActQuantize, 15'd257, 24'sd100);
    write_mode(1'b0);
    send_beat(ActMeasure, 15'd0, 24'sd5);
    send_beat(ActQuantize, 15'd0, -24'sd10);
  endtask

  // Well-formed vector: measure pass from index 0, then a quantize pass over the same indices
  task automatic run_vector();
    logic [IdxW-1:0]           idx_list [$];
    logic signed [SampleW-1:0] smp_list [$];
    logic [IdxW-1:0]           idx;
    logic signed [SampleW-1:0] smp;
    int unsigned               len;
    len = ($urandom_range(9) == 0) ? $urandom_range(40, GroupSize + 8) : $urandom_range(1, 20);
    idx = '0;
    for (int k = 0; k < len; k++) begin
      if (k != 0) idx = ($urandom_range(3) != 0) ? idx + 1'b1 : IdxW'($urandom);
      smp = rand_sample();
      send_beat(ActMeasure, idx, smp);
      idx = last_index;
      idx_list.insert(idx_list.size(), idx);
      smp_list.insert(smp_list.size(), smp);
    end
    if ($urandom_range(2) == 0) write_mode(1'($urandom_range(1)));
    foreach (idx_list[k]) begin
      smp = ($urandom_range(1) == 0) ? smp_list[k] : rand_sample();
      send_beat(ActQuantize, idx_list[k], smp);
    end
  endtask

  // Noise and broken passes: random actions, indices anywhere or near the start
  task automatic run_scramble();
    int unsigned     n;
    logic [IdxW-1:0] idx;
    n = $urandom_range(1, 12);
    repeat (n) begin
      idx = ($urandom_range(1) == 0) ? IdxW'($urandom_range(300)) : IdxW'($urandom);
      send_beat(logic'($urandom_range(1)), idx, rand_sample());
    end
  endtask

  task automatic test_random_vectors(input int unsigned send_pct, input int unsigned recv_pct,
                                     input int unsigned n_beats);
    int unsigned stop_at;
    write_mode(1'($urandom_range(1)));
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    stop_at = beats_sent + n_beats;
    while (beats_sent < stop_at) begin
      if ($urandom_range(3) != 0) run_vector();
      else run_scramble();
    end
  endtask

  initial begin
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_reset_scale_zero();
    test_field_extremes();
    test_group_rounding();
    test_zero_and_clip();
    test_random_vectors(24, 79, 150);
    test_random_vectors(79, 24, 150);
    test_random_vectors(0, 0, 150);
    settle();
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #RunLimit;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
